/* hdl/scnh_pkg.sv */
// Package for the segmented CRC-32C name hash: constants and the byte-wise CRC update.
package scnh_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned KEY_W  = 64;

    localparam logic [CRC_W-1:0] CRC_POLY_C = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] TOP_BIT    = 32'h8000_0000;
    localparam logic [CRC_W-1:0] HIGH_HALF  = 32'hFFFF_0000;
    localparam logic [CRC_W-1:0] MID_BIT    = 32'h0000_8000;

    // Separator characters
    localparam logic [BYTE_W-1:0] SEP_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] SEP_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] SEP_UNDER = 8'h5F;
    localparam logic [BYTE_W-1:0] SEP_TILDE = 8'h7E;

    // Key of the zero-length name
    localparam logic [KEY_W-1:0] EMPTY_KEY = {TOP_BIT, MID_BIT};

    // One byte through the reflected CRC-32C register (eight bit steps, an XOR tree)
    function automatic logic [CRC_W-1:0] crc32c_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] r;
        r = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY_C;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic is_separator(input logic [BYTE_W-1:0] b);
        return (b == SEP_DOT) || (b == SEP_DASH) || (b == SEP_UNDER) || (b == SEP_TILDE);
    endfunction

endpackage

/* hdl/segmented_crc32c_name_hash_top.sv */
// Segmented CRC-32C directory-name hash: one name byte per word in, one 64-bit key out.
// The last (or empty) word of a name passes the input register, then its key the result register.
// Throughput: one byte word per cycle unless a key waits on a stalled master side; the CRC
// byte update and the 32-bit segment add sit between the input register and the result register.
// Reset: i_rst_n is synchronous, active low; it empties both registers and restores
// the CRC presets, the segment sum and the open-segment flag.
module segmented_crc32c_name_hash_top
    import scnh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Slave side: name bytes
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,   // [7:0] name_byte
    input  logic              i_s_tlast,   // last_byte
    input  logic              i_s_tuser,   // [0] empty_name
    // Master side: keys
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [KEY_W-1:0]  o_m_tdata    // [63:0] hash_key
);

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_empty;

    // Hash state
    logic [CRC_W-1:0]  r_seg_crc, n_seg_crc;
    logic              r_seg_open, n_seg_open;
    logic [CRC_W-1:0]  r_seg_sum, n_seg_sum;
    logic [CRC_W-1:0]  r_whole_crc, n_whole_crc;

    // Result register
    logic              r_out_valid;
    logic [KEY_W-1:0]  r_key, n_key;

    logic              out_free;
    logic              advance;
    logic              emit;
    logic              sep;
    logic [CRC_W-1:0]  seg_step;
    logic [CRC_W-1:0]  whole_step;
    logic [CRC_W-1:0]  add_term;
    logic [CRC_W-1:0]  sum_total;
    logic [CRC_W-1:0]  whole_fin;
    logic [CRC_W-1:0]  mixed;

    // Handshake: the input word moves on whenever the result register can take a key
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign emit       = advance && (r_empty || r_last);

    // Capture incoming words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_byte  <= i_s_tdata;
            r_last  <= i_s_tlast;
            r_empty <= i_s_tuser;
        end
    end

    // CRC updates and the segment add
    always_comb begin
        sep        = is_separator(r_byte);
        seg_step   = crc32c_byte(r_seg_crc, r_byte);
        whole_step = crc32c_byte(r_whole_crc, r_byte);

        // A separator closes the open segment; an ordinary byte adds its segment's CRC only when it ends the name
        if (sep) begin
            add_term = r_seg_open ? ~r_seg_crc : '0;
        end else begin
            add_term = ~seg_step;
        end
        sum_total = r_seg_sum + add_term;

        whole_fin = ~whole_step;
        mixed     = whole_fin ^ (whole_fin << 16);

        if (r_empty) begin
            n_key = EMPTY_KEY;
        end else begin
            n_key = {sum_total | TOP_BIT, (mixed & HIGH_HALF) | MID_BIT};
        end

        n_whole_crc = whole_step;
        if (sep) begin
            n_seg_sum  = sum_total;
            n_seg_crc  = CRC_PRESET;
            n_seg_open = 1'b0;
        end else begin
            n_seg_sum  = r_seg_sum;
            n_seg_crc  = seg_step;
            n_seg_open = 1'b1;
        end

        // End of name (or empty name): back to presets
        if (r_empty || r_last) begin
            n_whole_crc = CRC_PRESET;
            n_seg_sum   = '0;
            n_seg_crc   = CRC_PRESET;
            n_seg_open  = 1'b0;
        end
    end

    // Hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_crc   <= CRC_PRESET;
            r_seg_open  <= 1'b0;
            r_seg_sum   <= '0;
            r_whole_crc <= CRC_PRESET;
        end else if (advance) begin
            r_seg_crc   <= n_seg_crc;
            r_seg_open  <= n_seg_open;
            r_seg_sum   <= n_seg_sum;
            r_whole_crc <= n_whole_crc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_key <= n_key;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_key;

endmodule

/* hdl/scnh_checker.sv */
// Port-level checker for the name hash top level, with its bind.
module scnh_checker
    import scnh_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_s_tready,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [KEY_W-1:0]  o_m_tdata
);

    // Every key carries bit 63 and bit 15 set and bits 14..0 clear
    a_key_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[63] && o_m_tdata[15] && (o_m_tdata[14:0] == '0)))
        else $error("key format broken");

    // Input back-pressure only while a key waits on a stalled master side
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without a waiting key");

    // No key right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("key valid after reset");

    // A stalled key holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled key changed");

endmodule

bind segmented_crc32c_name_hash_top scnh_checker u_scnh_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
